>>> hw/rtl/rmmst_pkg.sv
// Shared constants and types for the range min/max segment tree.
package rmmst_pkg;

    localparam int unsigned LEAVES = 1024;
    localparam int unsigned LEAF_W = $clog2(LEAVES);
    localparam int unsigned NODE_W = LEAF_W + 1;
    localparam int unsigned BOUND_W = LEAF_W + 1;
    localparam int unsigned DEPTH = 2 * LEAVES;
    localparam int unsigned DATA_W = 32;

    localparam logic signed [DATA_W-1:0] MIN_IDENT = 32'sd1000000000;
    localparam logic signed [DATA_W-1:0] MAX_IDENT = -32'sd1000000000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WLEAF,
        ST_WRD,
        ST_WWAIT,
        ST_WUP,
        ST_QSEL,
        ST_QWAIT,
        ST_QACC,
        ST_DONE
    } state_t;

    // Memory port bundle: two reads, one write of both trees.
    typedef struct packed {
        logic                     rd_en;
        logic [NODE_W-1:0]        rd_addr_a;
        logic [NODE_W-1:0]        rd_addr_b;
        logic                     wr_en;
        logic [NODE_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_min;
        logic signed [DATA_W-1:0] wr_max;
    } mem_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_a;
        logic signed [DATA_W-1:0] max_a;
        logic signed [DATA_W-1:0] min_b;
        logic signed [DATA_W-1:0] max_b;
    } mem_rsp_t;

endpackage

>>> hw/rtl/range_min_max_segment_tree_core.sv
// Top level of the range min/max segment tree.
// After reset the block sweeps both node memories to the sentinels with busy
// high. A write then keeps busy high while it writes the leaf and then, for
// each ancestor, reads its two children, waits for the registered read and
// writes the node; the last state is the done state. A query keeps busy high
// while it climbs the tree level by level with a read, a wait and an
// accumulate step per level; both sides of the range are read in the same
// memory cycle. An empty range goes straight to the done state. A new
// transfer is taken in the idle cycle after done. The result shows for one
// cycle with done high and cannot be held off by the receiver.
module range_min_max_segment_tree_core
    import rmmst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     opcode,
    input  logic [LEAF_W-1:0]        element_index,
    input  logic signed [DATA_W-1:0] value,
    input  logic [BOUND_W-1:0]       range_start,
    input  logic [BOUND_W-1:0]       range_end,
    output logic                     done,
    output logic signed [DATA_W-1:0] range_min,
    output logic signed [DATA_W-1:0] range_max,
    output logic                     range_empty
);

    state_t state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;      // write climb / query left
    logic [NODE_W:0] rnode_reg, rnode_next;      // query right, reaches 2*LEAVES
    logic take_l_reg, take_l_next;
    logic take_r_reg, take_r_next;
    logic signed [DATA_W-1:0] acc_min_reg, acc_min_next;
    logic signed [DATA_W-1:0] acc_max_reg, acc_max_next;
    logic empty_reg, empty_next;
    logic is_query_reg, is_query_next;
    logic signed [DATA_W-1:0] val_reg, val_next;

    mem_req_t req;
    mem_rsp_t rsp;

    rmmst_mem u_mem (.clk(clk), .req(req), .rsp(rsp));

    logic [BOUND_W-1:0] lo_sat, hi_sat;
    logic signed [DATA_W-1:0] cmin, cmax, qmin, qmax;

    always_comb
    begin
        lo_sat = (range_start > BOUND_W'(LEAVES)) ? BOUND_W'(LEAVES) : range_start;
        hi_sat = (range_end > BOUND_W'(LEAVES)) ? BOUND_W'(LEAVES) : range_end;
        cmin = (rsp.min_a < rsp.min_b) ? rsp.min_a : rsp.min_b;
        cmax = (rsp.max_a > rsp.max_b) ? rsp.max_a : rsp.max_b;
        qmin = acc_min_reg;
        qmax = acc_max_reg;
        if (take_l_reg)
        begin
            qmin = (rsp.min_a < qmin) ? rsp.min_a : qmin;
            qmax = (rsp.max_a > qmax) ? rsp.max_a : qmax;
        end
        if (take_r_reg)
        begin
            qmin = (rsp.min_b < qmin) ? rsp.min_b : qmin;
            qmax = (rsp.max_b > qmax) ? rsp.max_b : qmax;
        end
    end

    // Next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        node_next     = node_reg;
        rnode_next    = rnode_reg;
        take_l_next   = take_l_reg;
        take_r_next   = take_r_reg;
        acc_min_next  = acc_min_reg;
        acc_max_next  = acc_max_reg;
        empty_next    = empty_reg;
        is_query_next = is_query_reg;
        val_next      = val_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                node_next = node_reg + 1'b1;
                if (node_reg == NODE_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next      = value;
                    is_query_next = (opcode == OP_QUERY);
                    empty_next    = 1'b0;
                    acc_min_next  = MIN_IDENT;
                    acc_max_next  = MAX_IDENT;
                    if (opcode == OP_WRITE)
                    begin
                        node_next  = NODE_W'(LEAVES) + NODE_W'(element_index);
                        state_next = ST_WLEAF;
                    end
                    else
                    begin
                        node_next  = NODE_W'(LEAVES) + NODE_W'(lo_sat);
                        rnode_next = (NODE_W+1)'(LEAVES) + (NODE_W+1)'(hi_sat);
                        empty_next = (lo_sat >= hi_sat);
                        state_next = (lo_sat >= hi_sat) ? ST_DONE : ST_QSEL;
                    end
                end
            end
            ST_WLEAF:
            begin
                node_next  = node_reg >> 1;
                state_next = ST_WRD;
            end
            ST_WRD:
            begin
                state_next = ST_WWAIT;
            end
            ST_WWAIT:
            begin
                state_next = ST_WUP;
            end
            ST_WUP:
            begin
                node_next  = node_reg >> 1;
                state_next = (node_reg == NODE_W'(1)) ? ST_DONE : ST_WRD;
            end
            ST_QSEL:
            begin
                if ({1'b0, node_reg} < rnode_reg)
                begin
                    take_l_next = node_reg[0];
                    take_r_next = rnode_reg[0];
                    state_next  = ST_QWAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_QWAIT:
            begin
                // one extra bit so the step past the last node does not wrap
                node_next  = NODE_W'(({1'b0, node_reg} + (NODE_W+1)'(node_reg[0])) >> 1);
                rnode_next = rnode_reg >> 1;
                state_next = ST_QACC;
            end
            ST_QACC:
            begin
                acc_min_next = qmin;
                acc_max_next = qmax;
                state_next   = ST_QSEL;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory requests
    always_comb
    begin
        req.rd_en     = 1'b0;
        req.rd_addr_a = node_reg;
        req.rd_addr_b = rnode_reg[NODE_W-1:0];
        req.wr_en     = 1'b0;
        req.wr_addr   = node_reg;
        req.wr_min    = cmin;
        req.wr_max    = cmax;
        case (state_reg)
            ST_CLEAR:
            begin
                req.wr_en  = 1'b1;
                req.wr_min = MIN_IDENT;
                req.wr_max = MAX_IDENT;
            end
            ST_WLEAF:
            begin
                req.wr_en  = 1'b1;
                req.wr_min = val_reg;
                req.wr_max = val_reg;
            end
            ST_WRD:
            begin
                req.rd_en     = 1'b1;
                req.rd_addr_a = {node_reg[NODE_W-2:0], 1'b0};
                req.rd_addr_b = {node_reg[NODE_W-2:0], 1'b1};
            end
            ST_WUP:
            begin
                req.wr_en = 1'b1;
            end
            ST_QSEL:
            begin
                req.rd_en     = 1'b1;
                req.rd_addr_a = node_reg;
                req.rd_addr_b = NODE_W'(rnode_reg - 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        done        = (state_reg == ST_DONE);
        range_min   = is_query_reg ? acc_min_reg : '0;
        range_max   = is_query_reg ? acc_max_reg : '0;
        range_empty = is_query_reg & empty_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            node_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rnode_reg    <= rnode_next;
        take_l_reg   <= take_l_next;
        take_r_reg   <= take_r_next;
        acc_min_reg  <= acc_min_next;
        acc_max_reg  <= acc_max_next;
        empty_reg    <= empty_next;
        is_query_reg <= is_query_next;
        val_reg      <= val_next;
    end

endmodule

>>> hw/rtl/rmmst_mem.sv
// Node storage: min and max trees, two read ports, one write port.
module rmmst_mem
    import rmmst_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    logic signed [DATA_W-1:0] min_mem [DEPTH];
    logic signed [DATA_W-1:0] max_mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            min_mem[req.wr_addr] <= req.wr_min;
            max_mem[req.wr_addr] <= req.wr_max;
        end
    end

    // Registered reads
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rsp.min_a <= min_mem[req.rd_addr_a];
            rsp.max_a <= max_mem[req.rd_addr_a];
            rsp.min_b <= min_mem[req.rd_addr_b];
            rsp.max_b <= max_mem[req.rd_addr_b];
        end
    end

endmodule

>>> test/tb_top.sv
// Testbench for the range min/max segment tree core: predicts and checks every result.
`timescale 1ns / 100ps

module tb_top;
    import rmmst_pkg::*;

    // One pending command for the driver
    typedef struct {
        logic                     op;
        logic [LEAF_W-1:0]        idx;
        logic signed [DATA_W-1:0] val;
        logic [BOUND_W-1:0]       lo;
        logic [BOUND_W-1:0]       hi;
        bit                       drain;   // pause until all results are back
    } cmd_t;

    typedef struct {
        logic signed [DATA_W-1:0] mn;
        logic signed [DATA_W-1:0] mx;
        logic                     empty;
    } range_res_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     opcode;
    logic [LEAF_W-1:0]        element_index;
    logic signed [DATA_W-1:0] value;
    logic [BOUND_W-1:0]       range_start;
    logic [BOUND_W-1:0]       range_end;
    logic                     done;
    logic signed [DATA_W-1:0] range_min;
    logic signed [DATA_W-1:0] range_max;
    logic                     range_empty;

    cmd_t       cmd_q[$];
    range_res_t expected_q[$];
    int         fail_cnt;
    bit         stim_done;

    // Shadow copy of the leaves; queries scan them directly
    logic signed [DATA_W-1:0] leaf_val[LEAVES];
    bit                       leaf_set[LEAVES];

    range_min_max_segment_tree_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .element_index (element_index),
        .value         (value),
        .range_start   (range_start),
        .range_end     (range_end),
        .done          (done),
        .range_min     (range_min),
        .range_max     (range_max),
        .range_empty   (range_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted command to the shadow leaves and queue its result
    function automatic void predict_range(cmd_t c);
        range_res_t r;
        int unsigned lo;
        int unsigned hi;
        r.mn = '0;
        r.mx = '0;
        r.empty = 1'b0;
        if (c.op == OP_WRITE)
        begin
            leaf_val[c.idx] = c.val;
            leaf_set[c.idx] = 1'b1;
        end
        else
        begin
            lo = (c.lo > LEAVES) ? LEAVES : c.lo;
            hi = (c.hi > LEAVES) ? LEAVES : c.hi;
            r.mn = MIN_IDENT;
            r.mx = MAX_IDENT;
            if (lo >= hi)
                r.empty = 1'b1;
            else
                for (int unsigned i = lo; i < hi; i++)
                begin
                    // unwritten leaves hold the sentinels, which never change the result
                    if (leaf_set[i] && leaf_val[i] < r.mn) r.mn = leaf_val[i];
                    if (leaf_set[i] && leaf_val[i] > r.mx) r.mx = leaf_val[i];
                end
        end
        expected_q.push_back(r);
    endfunction

    function automatic cmd_t make_write(int unsigned idx, logic signed [DATA_W-1:0] v);
        cmd_t c;
        c.op = OP_WRITE;
        c.idx = LEAF_W'(idx);
        c.val = v;
        c.lo = BOUND_W'($urandom);
        c.hi = BOUND_W'($urandom);
        c.drain = 1'b0;
        return c;
    endfunction

    function automatic cmd_t make_query(int unsigned lo, int unsigned hi);
        cmd_t c;
        c.op = OP_QUERY;
        c.idx = LEAF_W'($urandom);
        c.val = $urandom;
        c.lo = BOUND_W'(lo);
        c.hi = BOUND_W'(hi);
        c.drain = 1'b0;
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: return $signed($urandom_range(0, 200)) - 100;
            2: return $urandom_range(0, 1) ? MIN_IDENT : MAX_IDENT;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: directed items, then random ones
    initial
    begin
        cmd_t c;
        int unsigned lo;
        int unsigned hi;
        for (int i = 0; i < LEAVES; i++)
            leaf_set[i] = 1'b0;
        // query over untouched leaves, then extremes of values and indexes
        cmd_q.push_back(make_query(0, LEAVES));
        cmd_q.push_back(make_query(5, 9));
        cmd_q.push_back(make_write(0, 32'sh7fffffff));
        cmd_q.push_back(make_write(LEAVES - 1, 32'sh80000000));
        cmd_q.push_back(make_write(512, 0));
        cmd_q.push_back(make_write(511, -1));
        cmd_q.push_back(make_query(0, LEAVES));
        cmd_q.push_back(make_query(0, 1));
        cmd_q.push_back(make_query(LEAVES - 1, LEAVES));
        cmd_q.push_back(make_query(1, LEAVES - 1));
        // bounds beyond the tree get saturated
        cmd_q.push_back(make_query(2047, 2047));
        cmd_q.push_back(make_query(500, 2047));
        cmd_q.push_back(make_query(1025, 3));
        // empty and reversed ranges
        cmd_q.push_back(make_query(7, 7));
        cmd_q.push_back(make_query(600, 100));
        cmd_q.push_back(make_query(0, 0));
        cmd_q.push_back(make_query(LEAVES, LEAVES));
        cmd_q.push_back(make_write(0, 32'sh55555555));
        cmd_q.push_back(make_write(1023, 32'shaaaaaaaa));
        cmd_q.push_back(make_query(0, 2));
        cmd_q[$].drain = 1'b1;
        // random part: writes weighted toward a small hot region for dense queries
        for (int n = 0; n < 1850; n++)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                if ($urandom_range(0, 1))
                    c = make_write($urandom_range(0, 63), rand_value());
                else
                    c = make_write($urandom_range(0, LEAVES - 1), rand_value());
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        lo = $urandom_range(0, 2047);
                        hi = $urandom_range(0, 2047);
                    end
                    1:
                    begin
                        lo = $urandom_range(0, 64);
                        hi = $urandom_range(0, 64);
                    end
                    2:
                    begin
                        lo = $urandom_range(0, LEAVES - 1);
                        hi = lo + 1;
                    end
                    default:
                    begin
                        lo = $urandom_range(0, LEAVES);
                        hi = $urandom_range(lo, LEAVES);
                    end
                endcase
                c = make_query(lo, hi);
            end
            c.drain = (n == 900);
            cmd_q.push_back(c);
        end
    end

    // Driver: bursts of back-to-back commands separated by random gaps
    int burst_left;
    int gap_left;
    bit drain_wait;
    cmd_t cur;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            opcode <= OP_WRITE;
            element_index <= '0;
            value <= '0;
            range_start <= '0;
            range_end <= '0;
            burst_left <= 0;
            gap_left <= 0;
            drain_wait <= 1'b0;
            stim_done <= 1'b0;
        end
        else if (start && busy)
        begin
            // hold the command until it is taken
        end
        else
        begin
            // start high with busy low: the command transfers at this edge
            if (start)
                predict_range(cur);
            if (start && cur.drain)
            begin
                start <= 1'b0;
                drain_wait <= 1'b1;
            end
            else if (drain_wait)
            begin
                start <= 1'b0;
                if (expected_q.size() == 0)
                    drain_wait <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_q.size() == 0)
            begin
                start <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (burst_left <= 0)
            begin
                start <= 1'b0;
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            else
            begin
                cur = cmd_q.pop_front();
                start <= 1'b1;
                opcode <= cur.op;
                element_index <= cur.idx;
                value <= cur.val;
                range_start <= cur.lo;
                range_end <= cur.hi;
                burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest expectation
    always @(posedge clk)
    begin
        range_res_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result min=%0d max=%0d empty=%0b",
                         $time, range_min, range_max, range_empty);
                fail_cnt++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (range_min !== e.mn)
                begin
                    $display("%0t: range_min expected %0d actual %0d", $time, e.mn, range_min);
                    fail_cnt++;
                end
                if (range_max !== e.mx)
                begin
                    $display("%0t: range_max expected %0d actual %0d", $time, e.mx, range_max);
                    fail_cnt++;
                end
                if (range_empty !== e.empty)
                begin
                    $display("%0t: range_empty expected %0b actual %0b",
                             $time, e.empty, range_empty);
                    fail_cnt++;
                end
            end
        end
    end

    // Reset, then wait for the stimulus to drain
    initial
    begin
        fail_cnt = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && !start);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Timeout
    initial
    begin
        #10000000;
        $display("tb: failure");
        $finish;
    end

endmodule
